// ===== hdl/imh_pkg.sv =====
// Package for the indexed min-heap: widths, operation and status codes,
// controller states and the command/status structs. No dependencies.
package imh_pkg;
  localparam int MaxItems = 256;
  localparam int KeyWidth = 32;
  localparam int IdxW = $clog2(MaxItems);
  localparam int SlotW = $clog2(MaxItems + 1);
  localparam int CntW = 9;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_CHANGE = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_DISPATCH, S_RM_TAIL, S_UP_RD, S_UP_KEY, S_UP_CMP,
    S_DN_RD, S_DN_KEY, S_DN_CMP, S_PLACE, S_DONE
  } state_t;

  // Command from controller to datapath.
  typedef struct packed {
    logic clear_step;   // clear one slot_of_item entry
    logic capture;      // latch input item
    logic lookup;       // read slot_of_item of input item
    logic do_insert;    // open a hole at the tail and set key
    logic do_change;    // write new key, hole at item's slot
    logic rm_start;     // read root and tail items
    logic rm_finish;    // read tail key, clear removed item, hole at root
    logic up_read;      // read parent item
    logic up_key;       // read parent key
    logic up_swap;      // move parent down into the hole
    logic dn_read;      // read child items
    logic dn_key;       // read child keys
    logic dn_swap;      // move chosen child up into the hole
    logic place;        // write the moving item into the hole
    logic set_status;   // latch status code
    logic [1:0] status;
    logic out_load;     // load result register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] func;
    logic present;
    logic count_zero;
    logic up_go;        // cursor > 1 and parent key > moving key
    logic dn_go;        // chosen child exists and its key < moving key
    logic clear_done;
  } sts_t;
endpackage

// ===== hdl/imh_if.sv =====
// Valid/ready channel interfaces for the indexed min-heap.
// No dependencies.
interface imh_in_if;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic [7:0] item_index;
  logic [31:0] key_value;
  modport source(output valid, func, item_index, key_value, input ready);
  modport sink(input valid, func, item_index, key_value, output ready);
endinterface

interface imh_out_if;
  logic valid;
  logic ready;
  logic [7:0] removed_index;
  logic removed_valid;
  logic [1:0] status;
  logic [8:0] entry_count;
  logic heap_empty;
  logic was_present;
  modport source(output valid, removed_index, removed_valid, status, entry_count,
                 heap_empty, was_present, input ready);
  modport sink(input valid, removed_index, removed_valid, status, entry_count,
               heap_empty, was_present, output ready);
endinterface

// ===== hdl/imh_ctrl.sv =====
// Controller state machine of the indexed min-heap.
// Depends on imh_pkg.
module imh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            out_busy,
  input  imh_pkg::sts_t   sts,
  output imh_pkg::cmd_t   cmd
);
  imh_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= imh_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      imh_pkg::S_CLEAR: if (sts.clear_done) state_next = imh_pkg::S_IDLE;
      imh_pkg::S_IDLE: if (in_valid) state_next = imh_pkg::S_LOOKUP;
      imh_pkg::S_LOOKUP: state_next = imh_pkg::S_DISPATCH;
      imh_pkg::S_DISPATCH: begin
        case (sts.func)
          imh_pkg::FUNC_INSERT:
            state_next = sts.present ? imh_pkg::S_DONE : imh_pkg::S_UP_RD;
          imh_pkg::FUNC_CHANGE:
            state_next = sts.present ? imh_pkg::S_UP_RD : imh_pkg::S_DONE;
          imh_pkg::FUNC_REMOVE:
            state_next = sts.count_zero ? imh_pkg::S_DONE : imh_pkg::S_RM_TAIL;
          default: state_next = imh_pkg::S_DONE;
        endcase
      end
      imh_pkg::S_RM_TAIL: state_next = imh_pkg::S_DN_RD;
      imh_pkg::S_UP_RD: state_next = imh_pkg::S_UP_KEY;
      imh_pkg::S_UP_KEY: state_next = imh_pkg::S_UP_CMP;
      imh_pkg::S_UP_CMP: state_next = sts.up_go ? imh_pkg::S_UP_RD :
                                      imh_pkg::S_DN_RD;
      imh_pkg::S_DN_RD: state_next = imh_pkg::S_DN_KEY;
      imh_pkg::S_DN_KEY: state_next = imh_pkg::S_DN_CMP;
      imh_pkg::S_DN_CMP: state_next = sts.dn_go ? imh_pkg::S_DN_RD :
                                      imh_pkg::S_PLACE;
      imh_pkg::S_PLACE: state_next = imh_pkg::S_DONE;
      imh_pkg::S_DONE: if (!out_busy) state_next = imh_pkg::S_IDLE;
      default: state_next = imh_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      imh_pkg::S_CLEAR: cmd.clear_step = 1'b1;
      imh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      imh_pkg::S_LOOKUP: cmd.lookup = 1'b1;
      imh_pkg::S_DISPATCH: begin
        cmd.set_status = 1'b1;
        cmd.status = imh_pkg::ST_OK;
        case (sts.func)
          imh_pkg::FUNC_INSERT: begin
            if (sts.present) cmd.status = imh_pkg::ST_PRESENT;
            else cmd.do_insert = 1'b1;
          end
          imh_pkg::FUNC_CHANGE: begin
            if (!sts.present) cmd.status = imh_pkg::ST_ABSENT;
            else cmd.do_change = 1'b1;
          end
          imh_pkg::FUNC_REMOVE: begin
            if (sts.count_zero) cmd.status = imh_pkg::ST_EMPTY;
            else cmd.rm_start = 1'b1;
          end
          default: cmd.status = imh_pkg::ST_OK;
        endcase
      end
      imh_pkg::S_RM_TAIL: cmd.rm_finish = 1'b1;
      imh_pkg::S_UP_RD: cmd.up_read = 1'b1;
      imh_pkg::S_UP_KEY: cmd.up_key = 1'b1;
      imh_pkg::S_UP_CMP: cmd.up_swap = sts.up_go;
      imh_pkg::S_DN_RD: cmd.dn_read = 1'b1;
      imh_pkg::S_DN_KEY: cmd.dn_key = 1'b1;
      imh_pkg::S_DN_CMP: cmd.dn_swap = sts.dn_go;
      imh_pkg::S_PLACE: cmd.place = 1'b1;
      imh_pkg::S_DONE: cmd.out_load = !out_busy;
      default: cmd = '0;
    endcase
  end
endmodule

// ===== hdl/imh_dp.sv =====
// Datapath of the indexed min-heap: heap slot, position and key memories,
// cursor, count and the result register. Depends on imh_pkg.
module imh_dp (
  input  logic            clk,
  input  logic            rst,
  input  imh_pkg::cmd_t   cmd,
  output imh_pkg::sts_t   sts,
  input  logic [1:0]      in_func,
  input  logic [7:0]      in_item,
  input  logic [31:0]     in_key,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_removed_index,
  output logic            out_removed_valid,
  output logic [1:0]      out_status,
  output logic [8:0]      out_entry_count,
  output logic            out_heap_empty,
  output logic            out_was_present
);
  // Every memory read lands in a register and is used in the next cycle. The item
  // being sifted stays in cur_item/cur_key and its slot is a hole: each step
  // writes only the neighbor that moves, and the item is placed at the end.
  logic [imh_pkg::IdxW-1:0]     heap_slots [1:imh_pkg::MaxItems];
  logic [imh_pkg::SlotW-1:0]    slot_of_item [imh_pkg::MaxItems];
  logic [imh_pkg::KeyWidth-1:0] item_keys [imh_pkg::MaxItems];

  logic [1:0]                   func;
  logic [imh_pkg::IdxW-1:0]     item;
  logic [imh_pkg::KeyWidth-1:0] key;
  logic [imh_pkg::SlotW-1:0]    pos_q;
  logic                         present;
  logic [imh_pkg::SlotW-1:0]    count;
  logic [imh_pkg::SlotW-1:0]    cursor;
  logic [imh_pkg::IdxW-1:0]     cur_item, par_item, lc_item, rc_item, removed;
  logic [imh_pkg::KeyWidth-1:0] cur_key, par_key, lc_key, rc_key;
  logic                         rc_ok;
  logic [1:0]                   status;
  logic [imh_pkg::IdxW:0]       clr_addr;
  logic                         clear_done;

  logic [imh_pkg::SlotW:0]      lchild;
  logic [imh_pkg::SlotW-1:0]    rchild_s, lchild_s, parent_s;
  logic                         pick_right;
  logic [imh_pkg::IdxW-1:0]     child_item;
  logic [imh_pkg::KeyWidth-1:0] child_key;

  assign present = (pos_q != '0);
  assign parent_s = cursor >> 1;
  assign lchild = {cursor, 1'b0};
  assign lchild_s = lchild[imh_pkg::SlotW-1:0];
  assign rchild_s = lchild_s + imh_pkg::SlotW'(1);
  assign pick_right = rc_ok && (lc_key > rc_key);
  assign child_item = pick_right ? rc_item : lc_item;
  assign child_key = pick_right ? rc_key : lc_key;

  always_comb begin
    sts.func = func;
    sts.present = present;
    sts.count_zero = (count == '0);
    sts.up_go = (cursor > imh_pkg::SlotW'(1)) && (par_key > cur_key);
    sts.dn_go = (lchild <= {1'b0, count}) && (cur_key > child_key);
    sts.clear_done = clear_done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clear_done <= 1'b0;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        slot_of_item[clr_addr[imh_pkg::IdxW-1:0]] <= '0;
        clr_addr <= clr_addr + (imh_pkg::IdxW+1)'(1);
        if (clr_addr == (imh_pkg::IdxW+1)'(imh_pkg::MaxItems - 1)) clear_done <= 1'b1;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.out_load) out_valid <= 1'b1;

      if (cmd.capture) begin
        func <= in_func;
        item <= in_item[imh_pkg::IdxW-1:0];
        key <= in_key[imh_pkg::KeyWidth-1:0];
      end
      if (cmd.lookup) pos_q <= slot_of_item[item];
      if (cmd.set_status) status <= cmd.status;

      if (cmd.do_insert) begin
        count <= count + imh_pkg::SlotW'(1);
        cursor <= count + imh_pkg::SlotW'(1);
        cur_item <= item;
        cur_key <= key;
        item_keys[item] <= key;
      end
      if (cmd.do_change) begin
        cursor <= pos_q;
        cur_item <= item;
        cur_key <= key;
        item_keys[item] <= key;
      end
      if (cmd.rm_start) begin
        removed <= heap_slots[1];
        cur_item <= heap_slots[count];
      end
      if (cmd.rm_finish) begin
        cur_key <= item_keys[cur_item];
        slot_of_item[removed] <= '0;
        count <= count - imh_pkg::SlotW'(1);
        cursor <= imh_pkg::SlotW'(1);
      end

      if (cmd.up_read) par_item <= heap_slots[parent_s];
      if (cmd.up_key) par_key <= item_keys[par_item];
      if (cmd.up_swap) begin
        heap_slots[cursor] <= par_item;
        slot_of_item[par_item] <= cursor;
        cursor <= parent_s;
      end

      if (cmd.dn_read) begin
        lc_item <= heap_slots[lchild_s];
        rc_item <= heap_slots[rchild_s];
        rc_ok <= (lchild < {1'b0, count});
      end
      if (cmd.dn_key) begin
        lc_key <= item_keys[lc_item];
        rc_key <= item_keys[rc_item];
      end
      if (cmd.dn_swap) begin
        heap_slots[cursor] <= child_item;
        slot_of_item[child_item] <= cursor;
        cursor <= pick_right ? rchild_s : lchild_s;
      end

      // A remove that empties the heap places the removed item itself, which
      // must stay marked absent.
      if (cmd.place) begin
        heap_slots[cursor] <= cur_item;
        slot_of_item[cur_item] <= (count == '0) ? '0 : cursor;
      end

      if (cmd.out_load) begin
        out_removed_valid <= (func == imh_pkg::FUNC_REMOVE) &&
                             (status == imh_pkg::ST_OK);
        out_removed_index <= ((func == imh_pkg::FUNC_REMOVE) &&
                              (status == imh_pkg::ST_OK)) ? 8'(removed) : 8'd0;
        out_status <= status;
        out_entry_count <= 9'(count);
        out_heap_empty <= (count == '0);
        out_was_present <= present;
      end
    end
  end
endmodule

// ===== hdl/indexed_min_heap.sv =====
// Top level of the indexed min-heap priority queue: controller plus datapath.
// Depends on imh_pkg, imh_if, imh_ctrl and imh_dp.
//
//   channel | direction | payload
//   in_ch   | sink      | func, item_index, key_value
//   out_ch  | source    | removed_index, removed_valid, status, entry_count,
//           |           | heap_empty, was_present
//
// One item at a time. After the input transfer the block looks up the item's
// slot and dispatches: a flagged or unused operation goes to the result, a
// remove sifts down from the root, and insert and change sift up and then down,
// each level in read, key and compare states, before the item is placed. The
// next input transfer can be taken in the cycle after the result is loaded.
// After reset a clearing pass empties the position table before the first
// transfer is taken. A stalled result does not hold the block, only the next one.
module indexed_min_heap (
  input logic        clk,
  input logic        rst,
  imh_in_if.sink     in_ch,
  imh_out_if.source  out_ch
);
  imh_pkg::cmd_t cmd;
  imh_pkg::sts_t sts;

  imh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_busy(out_ch.valid), .sts(sts), .cmd(cmd)
  );

  imh_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_func(in_ch.func), .in_item(in_ch.item_index), .in_key(in_ch.key_value),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_removed_index(out_ch.removed_index),
    .out_removed_valid(out_ch.removed_valid),
    .out_status(out_ch.status), .out_entry_count(out_ch.entry_count),
    .out_heap_empty(out_ch.heap_empty), .out_was_present(out_ch.was_present)
  );
endmodule
